// File: design/nibble_sprite_run_decoder_assert.svh
// assertion macros for the sprite run decoder
`ifndef NIBBLE_SPRITE_RUN_DECODER_ASSERT_SVH
`define NIBBLE_SPRITE_RUN_DECODER_ASSERT_SVH

// property checked in the same cycle
`define NSRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// property checked in the next cycle
`define NSRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/nsrd_pkg.sv
package nsrd_pkg;

   typedef enum logic [1:0] {
      PH_SKIP  = 2'd0,
      PH_COUNT = 2'd1,
      PH_COLOR = 2'd2
   } phase_type;

   localparam logic [7:0] MARKER_BYTE = 8'hff;
   localparam logic [7:0] LO_NIBBLE   = 8'h0f;
   localparam logic [7:0] HI_NIBBLE   = 8'hf0;

   localparam logic [15:0] WIDTH_RESET = 16'd16;
   localparam int unsigned ROW_BITS    = 18;

   typedef struct packed {
      logic [15:0] pixel_offset;
      logic [3:0]  pixel_color;
      logic        image_done;
      logic        last_of_item;
   } result_type;

endpackage

// File: design/nibble_sprite_run_decoder.sv
// sprite run decoder: one encoded byte per item, up to two results per item
// results: first result of an item is valid the cycle after it is accepted
// throughput: one item per cycle while items give at most one result and the
// output is not stalled; a two-pixel item holds the single result port for both
// reset: synchronous, active high; width returns to 16, offset and phase clear
`include "nibble_sprite_run_decoder_assert.svh"

module nibble_sprite_run_decoder
   import nsrd_pkg::*;
#(
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] pixel_offset, [19:16] pixel_color
   output logic        rsp_tuser,   // [0] image_done
   output logic        rsp_tlast,   // last_of_item
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // image_width
);

   phase_type              phase_ff, phase_in;
   logic [6:0]             pairs_ff, pairs_in;
   logic                   odd_ff, odd_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic [1:0]             mrun_ff, mrun_in;
   logic [15:0]            width_ff;
   logic [1:0]             cnt_ff, cnt_in;
   result_type             slot0_ff, slot0_in, slot1_ff, slot1_in;

   logic                   acc, drain;
   logic [7:0]             b;
   logic [1:0]             mark_inc;
   logic [1:0]             res_n;
   result_type             res0, res1;
   logic [OFFSET_BITS-1:0] off_p1, off_p2, off_skip, off_row;
   logic [OFFSET_BITS+15:0] wide0, wide1;
   logic [OFFSET_BITS+7:0]  b_wide;
   logic [OFFSET_BITS+ROW_BITS-1:0] row_sext;

   assign b     = req_tdata;
   assign acc   = req_tvalid && req_tready;
   assign drain = rsp_tvalid && rsp_tready;

   // take a new item only if the result buffer will be empty after this edge
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {4'b0, slot0_ff.pixel_color, slot0_ff.pixel_offset};
   assign rsp_tuser  = slot0_ff.image_done;
   assign rsp_tlast  = slot0_ff.last_of_item;

   assign mark_inc = mrun_ff + 2'd1;
   assign off_p1   = off_ff + OFFSET_BITS'(1);
   assign off_p2   = off_ff + OFFSET_BITS'(2);
   assign b_wide   = {{OFFSET_BITS{1'b0}}, b};
   assign off_skip = off_ff + b_wide[OFFSET_BITS-1:0];
   // row remainder may be negative after an overrun, so sign extend it
   assign row_sext = {{OFFSET_BITS{row_ff[ROW_BITS-1]}}, row_ff};
   assign off_row  = off_ff + row_sext[OFFSET_BITS-1:0];
   assign wide0    = {16'b0, off_ff};
   assign wide1    = {16'b0, off_p1};

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (acc) begin
         unique case (phase_ff)
            PH_COUNT: begin
               if (b == MARKER_BYTE) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = (b != 8'd0) ? PH_COLOR : PH_SKIP;
               end
            end
            PH_COLOR: begin
               if (pairs_ff != 7'd0) begin
                  phase_in = ((pairs_ff == 7'd1) && !odd_ff) ? PH_SKIP : PH_COLOR;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
            default: begin
               phase_in = (b == MARKER_BYTE) ? PH_SKIP : PH_COUNT;
            end
         endcase
      end
   end

   // datapath and results
   always_comb begin
      pairs_in = pairs_ff;
      odd_in   = odd_ff;
      off_in   = off_ff;
      row_in   = row_ff;
      mrun_in  = mrun_ff;
      res_n    = 2'd0;
      res0     = '0;
      res1     = '0;
      if (acc) begin
         unique case (phase_ff)
            PH_COUNT: begin
               if (b != MARKER_BYTE) begin
                  mrun_in  = 2'd0;
                  pairs_in = b[7:1];
                  odd_in   = b[0];
               end else if (mark_inc == 2'd3) begin
                  pairs_in = 7'd0;
                  odd_in   = 1'b0;
                  off_in   = '0;
                  row_in   = {2'b0, width_ff};
                  mrun_in  = 2'd0;
                  res_n    = 2'd1;
                  res0.image_done   = 1'b1;
                  res0.last_of_item = 1'b1;
               end else begin
                  mrun_in = mark_inc;
               end
            end
            PH_COLOR: begin
               res0.pixel_offset = wide0[15:0];
               res0.pixel_color  = 4'(b & LO_NIBBLE);
               if (pairs_ff != 7'd0) begin
                  res1.pixel_offset = wide1[15:0];
                  res1.pixel_color  = 4'((b & HI_NIBBLE) >> 4);
                  res1.last_of_item = 1'b1;
                  res_n    = 2'd2;
                  off_in   = off_p2;
                  row_in   = row_ff - 18'd2;
                  pairs_in = pairs_ff - 7'd1;
               end else begin
                  res0.last_of_item = 1'b1;
                  res_n  = 2'd1;
                  off_in = off_p1;
                  row_in = row_ff - 18'd1;
                  odd_in = 1'b0;
               end
            end
            default: begin
               if (b != MARKER_BYTE) begin
                  mrun_in = 2'd0;
                  off_in  = off_skip;
                  row_in  = row_ff - {10'b0, b};
               end else begin
                  row_in = {2'b0, width_ff};
                  if (mark_inc == 2'd3) begin
                     pairs_in = 7'd0;
                     odd_in   = 1'b0;
                     off_in   = '0;
                     mrun_in  = 2'd0;
                     res_n    = 2'd1;
                     res0.image_done   = 1'b1;
                     res0.last_of_item = 1'b1;
                  end else begin
                     off_in  = off_row;
                     mrun_in = mark_inc;
                  end
               end
            end
         endcase
      end
   end

   // result buffer, at most two results of one item
   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (acc) begin
         cnt_in   = res_n;
         slot0_in = res0;
         slot1_in = res1;
      end else if (drain) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         pairs_ff <= 7'd0;
         odd_ff   <= 1'b0;
         off_ff   <= '0;
         row_ff   <= {2'b0, WIDTH_RESET};
         mrun_ff  <= 2'd0;
         width_ff <= WIDTH_RESET;
         cnt_ff   <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         pairs_ff <= pairs_in;
         odd_ff   <= odd_in;
         off_ff   <= off_in;
         row_ff   <= row_in;
         mrun_ff  <= mrun_in;
         cnt_ff   <= cnt_in;
         if (csr_we) begin
            width_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   `NSRD_ASSERT_NOW(a_full_blocks_input, clock, reset, cnt_ff == 2'd2, !req_tready,
      "input taken while two results are pending")
   `NSRD_ASSERT_NOW(a_pair_first_not_last, clock, reset, cnt_ff == 2'd2,
      !slot0_ff.last_of_item && slot1_ff.last_of_item, "pixel pair marked wrongly")
   `NSRD_ASSERT_NOW(a_done_empty, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_tlast && (rsp_tdata == 24'd0), "done result carries data")
   `NSRD_ASSERT_NEXT(a_done_clears, clock, reset, acc && res0.image_done,
      (off_ff == '0) && (phase_ff == PH_SKIP) && (mrun_ff == 2'd0),
      "state not cleared after image end")

endmodule
